// ----- hw/rtl/promotable_priority_table_assert.svh -----
// assertion macros for the promotable priority table
// needs nothing else; included by the files that carry assertions
`ifndef PROMOTABLE_PRIORITY_TABLE_ASSERT_SVH
`define PROMOTABLE_PRIORITY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PPT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PPT_ASSERT(lbl, clk, rst_n, prop)
`define PPT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/ppt_pkg.sv -----
// shared types and codes for the promotable priority table
// no dependencies
package ppt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_PROMOTE = 2'd1,
    REQ_GET_MAX = 2'd2,
    REQ_POP_MAX = 2'd3
  } ppt_req_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_ID_EXHAUSTED = 3'd4
  } ppt_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } ppt_state_e;

  localparam int unsigned IdWidth = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned ResPrioWidth = 16;

  typedef struct packed {
    ppt_req_e                req_type;
    logic [IdWidth-1:0]      entry_id;
    logic [FieldWidth-1:0]   payload;
  } ppt_req_t;

  typedef struct packed {
    ppt_status_e             status;
    logic [IdWidth-1:0]      result_id;
    logic [FieldWidth-1:0]   result_data;
    logic [ResPrioWidth-1:0] result_priority;
  } ppt_res_t;

endpackage

// ----- hw/rtl/ppt_ram.sv -----
// entry store of the priority table: one write port, one registered read port
// no dependencies
module ppt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 81,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ppt_engine.sv -----
// sequencer of the priority table: clearing pass, entry scan and write-back
// depends on ppt_pkg, ppt_ram and the assertion macro header
`include "promotable_priority_table_assert.svh"

module ppt_engine #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_vld_i,
  output logic              req_rdy_o,
  input  ppt_pkg::ppt_req_t req_i,
  output logic              res_vld_o,
  input  logic              res_rdy_i,
  output ppt_pkg::ppt_res_t res_o
);
  import ppt_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned MEM_W = 1 + IdWidth + PRIORITY_WIDTH + DATA_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  ppt_state_e state_q, state_d;

  ppt_req_t req_q;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic issue_done_q, issue_done_d;
  logic rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [IdWidth-1:0] best_id_q;
  logic [PRIORITY_WIDTH-1:0] best_prio_q;
  logic [DATA_WIDTH-1:0] best_data_q;

  logic [IdWidth-1:0] next_id_q;
  ppt_res_t res_q, res_d;

  // memory port
  logic mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;

  // fields of the entry just read
  logic rd_valid;
  logic [IdWidth-1:0] rd_ident;
  logic [PRIORITY_WIDTH-1:0] rd_prio;
  logic [DATA_WIDTH-1:0] rd_payload;
  logic hit;

  logic id_exhausted;
  logic [PRIORITY_WIDTH-1:0] prio_inc;

  assign rd_valid   = mem_rdata[MEM_W-1];
  assign rd_ident   = mem_rdata[PRIORITY_WIDTH+DATA_WIDTH +: IdWidth];
  assign rd_prio    = mem_rdata[DATA_WIDTH +: PRIORITY_WIDTH];
  assign rd_payload = mem_rdata[DATA_WIDTH-1:0];

  assign id_exhausted = (next_id_q == '1);
  assign prio_inc = (best_prio_q == '1) ? best_prio_q : best_prio_q + 1'b1;

  ppt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (MEM_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(cnt_q),
    .rdata_o(mem_rdata)
  );

  // which entry read this cycle becomes the selected one
  always_comb begin
    case (req_q.req_type)
      REQ_ADD: begin
        hit = !found_q && !rd_valid;
      end
      REQ_PROMOTE: begin
        hit = !found_q && rd_valid && (rd_ident == req_q.entry_id);
      end
      default: begin
        hit = rd_valid && (!found_q || (rd_prio > best_prio_q) ||
              ((rd_prio == best_prio_q) && (rd_ident > best_id_q)));
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_vld_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (issue_done_q && !rd_vld_q) state_d = S_WRITE;
      end
      S_WRITE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_rdy_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_rdy_o    = 1'b0;
    res_vld_o    = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = best_idx_q;
    mem_wdata    = '0;
    cnt_d        = cnt_q;
    issue_done_d = issue_done_q;
    res_d        = res_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        cnt_d     = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
      end
      S_IDLE: begin
        req_rdy_o    = 1'b1;
        cnt_d        = '0;
        issue_done_d = 1'b0;
      end
      S_SCAN: begin
        mem_re = !issue_done_q;
        if (!issue_done_q) begin
          if (cnt_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_WRITE: begin
        res_d = '{status: ST_OK, result_id: '0, result_data: '0,
                  result_priority: '0};
        case (req_q.req_type)
          REQ_ADD: begin
            if (id_exhausted) begin
              res_d.status = ST_ID_EXHAUSTED;
            end else if (!found_q) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              mem_wdata = {1'b1, next_id_q, {PRIORITY_WIDTH{1'b0}},
                           DATA_WIDTH'(req_q.payload)};
              res_d.result_id = next_id_q;
            end
          end
          REQ_PROMOTE: begin
            res_d.result_id = req_q.entry_id;
            if (!found_q) begin
              res_d.status = ST_NOT_FOUND;
            end else begin
              mem_we = 1'b1;
              mem_wdata = {1'b1, best_id_q, prio_inc, best_data_q};
              res_d.result_priority = ResPrioWidth'(prio_inc);
            end
          end
          default: begin
            if (!found_q) begin
              res_d.status = ST_EMPTY;
            end else begin
              // pop clears the valid bit, the rest of the word stays as read
              mem_we = (req_q.req_type == REQ_POP_MAX);
              mem_wdata = {1'b0, best_id_q, best_prio_q, best_data_q};
              res_d.result_id = best_id_q;
              res_d.result_data = FieldWidth'(best_data_q);
              res_d.result_priority = ResPrioWidth'(best_prio_q);
            end
          end
        endcase
      end
      S_DONE: begin
        res_vld_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      next_id_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= mem_re;
      if (state_q == S_IDLE) begin
        found_q <= 1'b0;
      end else if (rd_vld_q && hit) begin
        found_q <= 1'b1;
      end
      if (state_q == S_WRITE && req_q.req_type == REQ_ADD && !id_exhausted && found_q) begin
        next_id_q <= next_id_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_vld_i) begin
      req_q <= req_i;
    end
    if (mem_re) begin
      rd_idx_q <= cnt_q;
    end
    if (rd_vld_q && hit) begin
      best_idx_q  <= rd_idx_q;
      best_id_q   <= rd_ident;
      best_prio_q <= rd_prio;
      best_data_q <= rd_payload;
    end
    if (state_q == S_WRITE) begin
      res_q <= res_d;
    end
  end

  `PPT_ASSERT(a_no_write_in_scan, clk_i, rst_ni, (state_q == S_SCAN) |-> !mem_we)
  `PPT_ASSERT(a_read_data_in_scan, clk_i, rst_ni, rd_vld_q |-> (state_q == S_SCAN))
  `PPT_ASSERT(a_id_steps_by_one, clk_i, rst_ni, (next_id_q != $past(next_id_q)) |-> (next_id_q == $past(next_id_q) + 32'd1))
  `PPT_ASSERT(a_write_then_done, clk_i, rst_ni, (state_q == S_WRITE) |=> (state_q == S_DONE))
  `PPT_ASSERT_NEVER(a_no_read_when_idle, clk_i, rst_ni, mem_re && (state_q != S_SCAN))

endmodule

// ----- hw/rtl/promotable_priority_table.sv -----
// top level of the promotable priority table: stream ports and result register
// depends on ppt_pkg and ppt_engine (which holds ppt_ram)

// a table of CAPACITY entries, each an id, a priority and a data word, kept in
// one single-port-read, single-port-write ram with a registered read; one
// request is served at a time: add stores the data word at priority 0 in the
// lowest free entry and returns a fresh id from a counter, promote raises the
// priority of the entry with the given id by one (saturating), get max
// reports the entry with the greatest priority (ties go to the most recently
// added entry, i.e. the greatest id) and pop max reports and removes it;
// every request walks the whole ram, one entry read per cycle, a pace set by
// that single ram read port; the result sits in an output register, so the
// next request can be taken while the previous result waits; after reset a
// clearing pass over all CAPACITY entries marks every entry free, and
// s_axis_tready stays low until it ends
module promotable_priority_table #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // entry_id [31:0], payload [63:32]
  input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // result_id [31:0], result_data [63:32],
                                      // result_priority [79:64]
  output logic [2:0]  m_axis_tuser    // status [2:0]
);
  import ppt_pkg::*;

  ppt_req_t req;
  ppt_res_t res;
  logic     res_vld;
  logic     res_rdy;

  ppt_res_t out_q;
  logic     out_vld_q;

  // unpack the request
  assign req.req_type = ppt_req_e'(s_axis_tuser);
  assign req.entry_id = s_axis_tdata[31:0];
  assign req.payload  = s_axis_tdata[63:32];

  ppt_engine #(
    .CAPACITY      (CAPACITY),
    .DATA_WIDTH    (DATA_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_vld_i(s_axis_tvalid),
    .req_rdy_o(s_axis_tready),
    .req_i    (req),
    .res_vld_o(res_vld),
    .res_rdy_i(res_rdy),
    .res_o    (res)
  );

  // output register is free when empty or being drained this cycle
  assign res_rdy = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && res_rdy) begin
      out_q <= res;
    end
  end

  // pack the result
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.result_priority, out_q.result_data, out_q.result_id};

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for promotable_priority_table: directed and random requests
// with random gaps on both streams, answers checked against a shadow copy of the table
// depends on ppt_pkg and the promotable_priority_table rtl
module testbench;
  import ppt_pkg::*;

  localparam int unsigned TABLE_SLOTS = 64;
  localparam logic [15:0] PRIO_MAX = 16'hffff;
  // clearing pass plus a full walk per request plus the longest gaps, many times over
  localparam int WATCHDOG_LIMIT = 3000;
  // a request walks the whole table before it answers
  localparam int DRAIN_WAIT = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // entry_id [31:0], payload [63:32]
  logic [1:0]  s_axis_tuser;   // req_type [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // result_id [31:0], result_data [63:32],
                               // result_priority [79:64]
  logic [2:0]  m_axis_tuser;   // status [2:0]

  promotable_priority_table #(
    .CAPACITY      (TABLE_SLOTS),
    .DATA_WIDTH    (32),
    .PRIORITY_WIDTH(16)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow copy of the table
  bit          slot_live [TABLE_SLOTS];
  logic [31:0] slot_ident[TABLE_SLOTS];
  logic [15:0] slot_prio [TABLE_SLOTS];
  logic [31:0] slot_data [TABLE_SLOTS];
  logic [31:0] ident_counter;
  logic [31:0] last_freed_ident;

  ppt_res_t answers_due[$];
  ppt_res_t want;
  int       mismatches;
  int       idle_cycles;
  int       stall_left;
  bit       gaps_enabled;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // answer the table gives to one request, updating the shadow copy
  function automatic ppt_res_t serve_request(ppt_req_e kind, logic [31:0] id,
                                             logic [31:0] data);
    ppt_res_t ans;
    int slot;
    int best;
    ans  = '0;
    slot = -1;
    best = -1;
    case (kind)
      REQ_ADD: begin
        for (int k = 0; k < TABLE_SLOTS; k++)
          if (!slot_live[k] && slot < 0) slot = k;
        // exhausted ids are checked ahead of a full table
        if (ident_counter == '1) begin
          ans.status = ST_ID_EXHAUSTED;
        end else if (slot < 0) begin
          ans.status = ST_FULL;
        end else begin
          slot_live[slot]  = 1'b1;
          slot_ident[slot] = ident_counter;
          slot_prio[slot]  = '0;
          slot_data[slot]  = data;
          ans.result_id    = ident_counter;
          ident_counter++;
        end
      end
      REQ_PROMOTE: begin
        ans.result_id = id;
        for (int k = 0; k < TABLE_SLOTS; k++)
          if (slot_live[k] && slot_ident[k] == id && slot < 0) slot = k;
        if (slot < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          if (slot_prio[slot] != PRIO_MAX) slot_prio[slot]++;
          ans.result_priority = slot_prio[slot];
        end
      end
      default: begin
        // greatest priority, ties to the greatest (newest) id
        for (int k = 0; k < TABLE_SLOTS; k++)
          if (slot_live[k] && (best < 0 || slot_prio[k] > slot_prio[best] ||
              (slot_prio[k] == slot_prio[best] && slot_ident[k] > slot_ident[best])))
            best = k;
        if (best < 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.result_id       = slot_ident[best];
          ans.result_data     = slot_data[best];
          ans.result_priority = slot_prio[best];
          if (kind == REQ_POP_MAX) begin
            slot_live[best]  = 1'b0;
            last_freed_ident = slot_ident[best];
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int k = 0; k < TABLE_SLOTS; k++) n += slot_live[k];
    return n;
  endfunction

  // id of a live entry, the lowest slot when asked, random bits on an empty table
  function automatic logic [31:0] pick_live_ident(bit favour_low);
    int live[$];
    for (int k = 0; k < TABLE_SLOTS; k++)
      if (slot_live[k]) live.insert(live.size(), k);
    if (live.size() == 0) return $urandom;
    if (favour_low) return slot_ident[live[0]];
    return slot_ident[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  // id that is most likely not in the table: random, not yet issued, or freed
  function automatic logic [31:0] stray_ident();
    case ($urandom_range(0, 2))
      0:       return $urandom;
      1:       return ident_counter + $urandom_range(0, 3);
      default: return last_freed_ident;
    endcase
  endfunction

  // mostly back to back, sometimes a few cycles, now and then a long pause
  function automatic int pick_gap();
    int r;
    if (!gaps_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request: optional gap, then hold until accepted, then predict its answer
  task automatic send_request(input ppt_req_e kind, input logic [31:0] id,
                              input logic [31:0] data);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {data, id};
    do @(posedge clk_i); while (!s_axis_tready);
    answers_due.insert(answers_due.size(), serve_request(kind, id, data));
  endtask

  function automatic void note_mismatch(string what, logic [31:0] exp_val,
                                        logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, exp_val, act_val);
  endfunction

  // empty table, unknown ids, tie order and removal; ids running out and
  // priority saturation need far more requests than a run can spend
  task automatic test_directed_cases();
    logic [31:0] base;
    send_request(REQ_GET_MAX, '0, '0);
    send_request(REQ_POP_MAX, '1, '1);
    send_request(REQ_PROMOTE, '0, '1);
    send_request(REQ_PROMOTE, '1, '0);
    base = ident_counter;
    send_request(REQ_ADD, '1, '0);
    send_request(REQ_ADD, '0, '1);
    send_request(REQ_ADD, '0, 32'h5a5a_a5a5);
    send_request(REQ_GET_MAX, '1, '1);        // three-way tie at zero
    send_request(REQ_PROMOTE, base, '0);
    send_request(REQ_PROMOTE, base + 1, '1);
    send_request(REQ_GET_MAX, '0, '0);        // tie at one, newer wins
    send_request(REQ_PROMOTE, base, '0);
    send_request(REQ_POP_MAX, '0, '0);
    send_request(REQ_PROMOTE, base, '0);      // just removed
    send_request(REQ_POP_MAX, '0, '0);
    send_request(REQ_GET_MAX, '0, '0);
    send_request(REQ_POP_MAX, '0, '0);
    send_request(REQ_POP_MAX, '0, '0);        // empty again
    send_request(REQ_ADD, $urandom, $urandom); // freed slot reused
    send_request(REQ_POP_MAX, $urandom, $urandom);
  endtask

  // fill to the brim, add past it, then drain and read past empty
  task automatic test_fill_and_drain();
    int r;
    for (int lap = 0; lap < 2; lap++) begin
      gaps_enabled = (lap == 0);
      while (live_count() < TABLE_SLOTS) begin
        if ($urandom_range(0, 3) == 0) send_request(REQ_PROMOTE, pick_live_ident(0), $urandom);
        else send_request(REQ_ADD, $urandom, $urandom);
      end
      repeat (4) send_request(REQ_ADD, $urandom, $urandom);
      send_request(REQ_PROMOTE, stray_ident(), $urandom);
      while (live_count() > 0) begin
        r = $urandom_range(0, 9);
        if (r < 7) send_request(REQ_POP_MAX, $urandom, $urandom);
        else if (r < 8) send_request(REQ_GET_MAX, $urandom, $urandom);
        else send_request(REQ_PROMOTE, pick_live_ident(0), $urandom);
      end
      send_request(REQ_GET_MAX, $urandom, $urandom);
      send_request(REQ_POP_MAX, $urandom, $urandom);
      send_request(REQ_PROMOTE, stray_ident(), $urandom);
    end
    gaps_enabled = 1'b1;
  endtask

  // a handful of entries promoted hard, so the order of the max keeps shifting
  task automatic test_hot_promotes();
    int r;
    for (int n = 0; n < 250; n++) begin
      r = $urandom_range(0, 99);
      if (live_count() < 3 || (r < 12 && live_count() < 8))
        send_request(REQ_ADD, $urandom, $urandom);
      else if (r < 70) send_request(REQ_PROMOTE, pick_live_ident(r < 40), $urandom);
      else if (r < 85) send_request(REQ_GET_MAX, $urandom, $urandom);
      else send_request(REQ_POP_MAX, $urandom, $urandom);
    end
  endtask

  // long random mix, table depth steered around a level that changes now and then
  task automatic test_mixed_traffic();
    int r;
    int add_w;
    int level;
    level = TABLE_SLOTS / 2;
    for (int n = 0; n < 1100; n++) begin
      if (n % 150 == 0) begin
        gaps_enabled = ($urandom_range(0, 3) != 0);
        level = $urandom_range(2, TABLE_SLOTS + 2);
      end
      add_w = (live_count() > level) ? 15 : 32;
      r = $urandom_range(0, 99);
      if (r < add_w) begin
        send_request(REQ_ADD, $urandom, $urandom);
      end else if (r < add_w + 38) begin
        if ($urandom_range(0, 4) != 0) send_request(REQ_PROMOTE, pick_live_ident(0), $urandom);
        else send_request(REQ_PROMOTE, stray_ident(), $urandom);
      end else if (r < add_w + 50) begin
        send_request(REQ_GET_MAX, $urandom, $urandom);
      end else begin
        send_request(REQ_POP_MAX, $urandom, $urandom);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // result side: ready drops for random stretches
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // answer checker, oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("unexpected answer id", '0, m_axis_tdata[31:0]);
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tuser !== want.status)
          note_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[31:0] !== want.result_id)
          note_mismatch("result_id", want.result_id, m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== want.result_data)
          note_mismatch("result_data", want.result_data, m_axis_tdata[63:32]);
        if (m_axis_tdata[79:64] !== want.result_priority)
          note_mismatch("result_priority", want.result_priority, m_axis_tdata[79:64]);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ADD;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    gaps_enabled  = 1'b1;
    ident_counter = '0;
    last_freed_ident = '0;
    for (int k = 0; k < TABLE_SLOTS; k++) slot_live[k] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_hot_promotes();
    test_mixed_traffic();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_ram.sv
hw/rtl/ppt_engine.sv
hw/rtl/promotable_priority_table.sv
tb/sv/testbench.sv
